### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`endif
`endif

### rtl/core/rm2q_pkg.sv
// ----------------------------------------------------------------------------
// rm2q_pkg
// Types and constants of the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
`default_nettype none
package rm2q_pkg;
  localparam int WORD_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int RAD_W      = WORD_WIDTH + 1;
  localparam int N_W        = 2 * WORD_WIDTH;
  localparam int ROOT_W     = WORD_WIDTH;
  localparam int SQREM_W    = ROOT_W + 2;
  localparam int MAG_W      = WORD_WIDTH + 1;
  localparam int NQ_W       = MAG_W + FRAC_BITS;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int SQRT_CELLS = N_W / 2;
  localparam int DIV_CELLS  = NQ_W;
  localparam int LANES      = 3;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  typedef struct packed {
    slot_t                 hslot;
    slot_t [LANES-1:0]     dslot;
    logic  [LANES-1:0]     neg;
    logic                  clamp;
  } ctl_t;

  typedef struct packed {
    ctl_t                          ctl;
    logic [N_W-1:0]                n;
    logic [SQREM_W-1:0]            rem;
    logic [ROOT_W-1:0]             root;
    logic [LANES-1:0][MAG_W-1:0]   mag;
  } sq_t;

  typedef struct packed {
    ctl_t                          ctl;
    logic [ROOT_W-1:0]             root;
    logic [LANES-1:0][NQ_W-1:0]    nq;
    logic [LANES-1:0][DREM_W-1:0]  rem;
  } dv_t;
endpackage
`default_nettype wire

### rtl/core/rm2q_mat_if.sv
// ----------------------------------------------------------------------------
// rm2q_mat_if
// Matrix channel: valid, ready and nine Q2.14 elements.
// ----------------------------------------------------------------------------
`default_nettype none
interface rm2q_mat_if import rm2q_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t m_r0c0, m_r0c1, m_r0c2;
  word_t m_r1c0, m_r1c1, m_r1c2;
  word_t m_r2c0, m_r2c1, m_r2c2;
  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface
`default_nettype wire

### rtl/core/rm2q_quat_if.sv
// ----------------------------------------------------------------------------
// rm2q_quat_if
// Quaternion channel: valid, ready, four Q2.14 components and a flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface rm2q_quat_if import rm2q_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t quat_w, quat_x, quat_y, quat_z;
  logic  saturated;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, saturated,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, saturated,
                output ready);
endinterface
`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a Q2.14 rotation matrix into the Q2.14 quaternion (w,x,y,z).
// ----------------------------------------------------------------------------
// The core takes one matrix per cycle while the output is not stalled and
// returns one quaternion for each, in order, through the input preparation
// register, sixteen square root cells that each settle one root bit,
// thirty-one divider cells that each settle one quotient bit of all three
// off-diagonal terms, and the output register. Every cell passes its
// item on as soon as its neighbor has room, so a stall on the output only
// fills the chain behind it and the input keeps accepting until it is full.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core import rm2q_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  rm2q_mat_if.sink    mat,
  rm2q_quat_if.source quat
);
  logic sq_v [SQRT_CELLS+1];
  logic sq_r [SQRT_CELLS+1];
  sq_t  sq_d [SQRT_CELLS+1];
  logic dv_v [DIV_CELLS+1];
  logic dv_r [DIV_CELLS+1];
  dv_t  dv_d [DIV_CELLS+1];

  rm2q_prep u_prep (
    .clk, .rst,
    .in_valid (mat.valid),
    .in_ready (mat.ready),
    .in_m     ({mat.m_r2c2, mat.m_r2c1, mat.m_r2c0, mat.m_r1c2, mat.m_r1c1,
                mat.m_r1c0, mat.m_r0c2, mat.m_r0c1, mat.m_r0c0}),
    .out_valid(sq_v[0]),
    .out_ready(sq_r[0]),
    .out_data (sq_d[0])
  );

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    rm2q_sqrt_cell u_cell (
      .clk, .rst,
      .in_valid (sq_v[g]),
      .in_ready (sq_r[g]),
      .in_data  (sq_d[g]),
      .out_valid(sq_v[g+1]),
      .out_ready(sq_r[g+1]),
      .out_data (sq_d[g+1])
    );
  end

  always_comb begin
    dv_d[0].ctl = sq_d[SQRT_CELLS].ctl;
    dv_d[0].root = sq_d[SQRT_CELLS].root;
    for (int l = 0; l < LANES; l++) begin
      dv_d[0].nq[l] = {sq_d[SQRT_CELLS].mag[l], {FRAC_BITS{1'b0}}};
      dv_d[0].rem[l] = '0;
    end
  end
  assign dv_v[0] = sq_v[SQRT_CELLS];
  assign sq_r[SQRT_CELLS] = dv_r[0];

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    rm2q_div_cell u_cell (
      .clk, .rst,
      .in_valid (dv_v[g]),
      .in_ready (dv_r[g]),
      .in_data  (dv_d[g]),
      .out_valid(dv_v[g+1]),
      .out_ready(dv_r[g+1]),
      .out_data (dv_d[g+1])
    );
  end

  rm2q_post u_post (
    .clk, .rst,
    .in_valid(dv_v[DIV_CELLS]),
    .in_ready(dv_r[DIV_CELLS]),
    .in_data (dv_d[DIV_CELLS]),
    .quat
  );

  `ASSERT_IMPLIES(a_in_open, clk, rst, !sq_v[0], mat.ready)
  `ASSERT_IMPLIES(a_root_range, clk, rst, sq_v[SQRT_CELLS], sq_d[SQRT_CELLS].root <= ROOT_W'(46340))
  `ASSERT_IMPLIES(a_rem_below, clk, rst, dv_v[DIV_CELLS] && dv_d[DIV_CELLS].root != '0, dv_d[DIV_CELLS].rem[0] < {dv_d[DIV_CELLS].root, 1'b0})
endmodule
`default_nettype wire

### rtl/core/rm2q_prep.sv
// ----------------------------------------------------------------------------
// rm2q_prep
// Input stage: case selection, radicand and the three signed numerators.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_prep import rm2q_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [8:0][WORD_WIDTH-1:0] in_m,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sq_t                             out_data
);
  localparam logic signed [RAD_W+1:0] ONE = (RAD_W+2)'(1) <<< FRAC_BITS;

  sq_t data_next;
  logic en;

  function automatic logic signed [RAD_W+1:0] el(input logic [8:0][WORD_WIDTH-1:0] m,
                                                 input logic [1:0] r, input logic [1:0] c);
    logic [3:0] idx;
    idx = 4'(r) * 4'd3 + 4'(c);
    return (RAD_W+2)'($signed(m[idx]));
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  always_comb begin
    logic signed [RAD_W+1:0] trace, rad;
    logic signed [RAD_W+1:0] d [LANES];
    logic [1:0] ii, jj, kk;
    data_next = '0;
    trace = el(in_m, 2'd0, 2'd0) + el(in_m, 2'd1, 2'd1) + el(in_m, 2'd2, 2'd2);
    ii = 2'd0;
    if (el(in_m, 2'd1, 2'd1) > el(in_m, 2'd0, 2'd0)) ii = 2'd1;
    if (el(in_m, 2'd2, 2'd2) > el(in_m, ii, ii)) ii = 2'd2;
    jj = nxt(ii);
    kk = nxt(jj);
    if (trace > 0) begin
      rad = trace + ONE;
      d[0] = el(in_m, 2'd2, 2'd1) - el(in_m, 2'd1, 2'd2);
      d[1] = el(in_m, 2'd0, 2'd2) - el(in_m, 2'd2, 2'd0);
      d[2] = el(in_m, 2'd1, 2'd0) - el(in_m, 2'd0, 2'd1);
      data_next.ctl.hslot = SLOT_W;
      data_next.ctl.dslot[0] = SLOT_X;
      data_next.ctl.dslot[1] = SLOT_Y;
      data_next.ctl.dslot[2] = SLOT_Z;
    end else begin
      rad = el(in_m, ii, ii) - (el(in_m, jj, jj) + el(in_m, kk, kk)) + ONE;
      d[0] = el(in_m, kk, jj) - el(in_m, jj, kk);
      d[1] = el(in_m, jj, ii) + el(in_m, ii, jj);
      d[2] = el(in_m, kk, ii) + el(in_m, ii, kk);
      data_next.ctl.hslot = slot_t'(ii + 2'd1);
      data_next.ctl.dslot[0] = SLOT_W;
      data_next.ctl.dslot[1] = slot_t'(jj + 2'd1);
      data_next.ctl.dslot[2] = slot_t'(kk + 2'd1);
    end
    if (rad < 0) begin
      rad = '0;
      data_next.ctl.clamp = 1'b1;
    end
    data_next.n = {1'b0, rad[RAD_W-1:0], {FRAC_BITS{1'b0}}};
    for (int l = 0; l < LANES; l++) begin
      data_next.ctl.neg[l] = d[l] < 0;
      data_next.mag[l] = d[l] < 0 ? MAG_W'(-d[l]) : MAG_W'(d[l]);
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rm2q_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rm2q_sqrt_cell
// One root bit of the integer square root; passes the item to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_sqrt_cell import rm2q_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sq_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output sq_t       out_data
);
  sq_t data_next;
  logic en;

  always_comb begin
    logic [SQREM_W+1:0] rsh, trial;
    data_next = in_data;
    rsh = {in_data.rem, in_data.n[N_W-1 -: 2]};
    trial = {2'b00, in_data.root, 2'b01};
    data_next.n = {in_data.n[N_W-3:0], 2'b00};
    if (rsh >= trial) begin
      data_next.rem = SQREM_W'(rsh - trial);
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem = SQREM_W'(rsh);
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rm2q_div_cell.sv
// ----------------------------------------------------------------------------
// rm2q_div_cell
// One quotient bit for each of the three numerators over twice the root.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_div_cell import rm2q_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire dv_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output dv_t       out_data
);
  dv_t data_next;
  logic en;

  always_comb begin
    logic [DREM_W:0] rsh, dvs;
    logic ge;
    data_next = in_data;
    dvs = {1'b0, in_data.root, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      rsh = {in_data.rem[l], in_data.nq[l][NQ_W-1]};
      ge = rsh >= dvs;
      data_next.rem[l] = ge ? DREM_W'(rsh - dvs) : DREM_W'(rsh);
      data_next.nq[l] = {in_data.nq[l][NQ_W-2:0], ge};
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rm2q_post.sv
// ----------------------------------------------------------------------------
// rm2q_post
// Output register: signs, saturation and placement of the components.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_post import rm2q_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire dv_t  in_data,
  rm2q_quat_if.source quat
);
  localparam logic [NQ_W-1:0] POS_MAX = NQ_W'((1 << (WORD_WIDTH-1)) - 1);
  localparam logic [NQ_W-1:0] NEG_MAX = NQ_W'(1 << (WORD_WIDTH-1));

  word_t q [4];
  word_t q_next [4];
  logic  flag, flag_next, en;

  always_comb begin
    word_t v;
    flag_next = in_data.ctl.clamp;
    for (int s = 0; s < 4; s++) q_next[s] = '0;
    for (int l = 0; l < LANES; l++) begin
      v = '0;
      if (in_data.root != '0) begin
        if (in_data.ctl.neg[l]) begin
          if (in_data.nq[l] > NEG_MAX) begin
            v = word_t'(NEG_MAX);
            flag_next = 1'b1;
          end else begin
            v = -word_t'(in_data.nq[l][WORD_WIDTH-1:0]);
          end
        end else if (in_data.nq[l] > POS_MAX) begin
          v = word_t'(POS_MAX);
          flag_next = 1'b1;
        end else begin
          v = word_t'(in_data.nq[l][WORD_WIDTH-1:0]);
        end
      end
      q_next[in_data.ctl.dslot[l]] = v;
    end
    q_next[in_data.ctl.hslot] = word_t'(in_data.root >> 1);
  end

  assign en = !quat.valid || quat.ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= in_valid;
    end
    if (en) begin
      q <= q_next;
      flag <= flag_next;
    end
  end

  assign quat.quat_w = q[0];
  assign quat.quat_x = q[1];
  assign quat.quat_y = q[2];
  assign quat.quat_z = q[3];
  assign quat.saturated = flag;
endmodule
`default_nettype wire
